>>> src/clt_pkg.sv
package clt_pkg;

   localparam int TOKEN_W = 11;
   localparam int TOKEN_LIMIT = 1024;
   localparam logic [TOKEN_W-1:0] LIMIT_CAP =
      (TOKEN_LIMIT > 2047) ? 11'd2047 : TOKEN_W'(TOKEN_LIMIT);
   localparam logic [TOKEN_W-1:0] MAX_TOKENS_RESET = 11'd1024;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int MAX_RESULTS = 3;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             out_char;
      logic [TOKEN_W-1:0]     token_index;
   } result_type;

   typedef struct packed {
      logic [1:0]                         count;
      result_type [MAX_RESULTS-1:0]       res;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> src/command_line_tokenizer_core.sv
// Command-line tokenizer: takes one text byte (or an end marker) per item and
// emits token bytes, end-of-token marks and a final done item carrying the
// token count. The front end classifies each byte combinationally and
// accepts one item per clock while its result queue has room; the back end
// drains the queue at one result per clock while rsp_stall is low. An item
// producing k results (at most three) therefore uses the result port once per
// result, so sustained throughput is one item per cycle for ordinary text and
// drops only for the byte after a held slash, a zero byte and the end of the
// text, with the queue depth setting how long a burst is absorbed. A result
// passes the queue entry and then the output register before it is offered.
// Registers: ignore_quotes at 0x0, max_tokens at 0x4.
module command_line_tokenizer_core import clt_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_out_char,
   output logic [TOKEN_W-1:0] rsp_token_index,
   output logic               rsp_last,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   typedef enum logic {
      REG_IGNORE_QUOTES = 1'b0,
      REG_MAX_TOKENS    = 1'b1
   } reg_index_type;

   logic               ignore_quotes_ff;
   logic [TOKEN_W-1:0] max_tokens_ff;
   logic [TOKEN_W-1:0] limit;
   reg_index_type      reg_index;
   logic               csr_write;

   logic               q_push;
   logic               q_pop;
   bundle_type         q_push_data;
   bundle_type         q_head;
   q_status_type       q_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign limit      = (max_tokens_ff < LIMIT_CAP) ? max_tokens_ff : LIMIT_CAP;

   always_ff @(posedge clock) begin
      if (reset) begin
         ignore_quotes_ff <= 1'b0;
         max_tokens_ff    <= MAX_TOKENS_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_IGNORE_QUOTES: ignore_quotes_ff <= csr_pwdata[0];
            REG_MAX_TOKENS:    max_tokens_ff    <= csr_pwdata[TOKEN_W-1:0];
            default:           ignore_quotes_ff <= ignore_quotes_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_IGNORE_QUOTES: csr_prdata = {31'd0, ignore_quotes_ff};
         REG_MAX_TOKENS:    csr_prdata = {{(32 - TOKEN_W){1'b0}}, max_tokens_ff};
         default:           csr_prdata = '0;
      endcase
   end

   clt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_ch          (req_ch),
      .req_end_of_text (req_end_of_text),
      .ignore_quotes   (ignore_quotes_ff),
      .limit           (limit),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_push_data)
   );

   clt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .status    (q_status)
   );

   clt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (q_head),
      .q_status        (q_status),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_token_index (rsp_token_index),
      .rsp_last        (rsp_last)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DONE) |-> rsp_last)
      else $error("done item not marked last");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_status.full)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("queue pop while empty");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> (rsp_out_char == 8'd0))
      else $error("nonzero char on marker item");

endmodule

>>> src/clt_front.sv
module clt_front import clt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_text,
   input  logic               ignore_quotes,
   input  logic [TOKEN_W-1:0] limit,
   input  q_status_type       q_status,
   output logic               q_push,
   output bundle_type         q_data
);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_SLASH = 8'h2f;

   typedef enum logic [2:0] {
      PH_BETWEEN,
      PH_TOKEN,
      PH_QUOTE,
      PH_COMMENT,
      PH_COMMENT_STAR,
      PH_STOPPED
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               slash_ff, slash_in;
   logic [TOKEN_W-1:0] count_ff, count_in;
   bundle_type         bundle_in;
   logic               accept;

   function automatic result_type mk(kind_type k, logic [7:0] c, logic [TOKEN_W-1:0] idx);
      result_type r;
      r.kind        = k;
      r.out_char    = c;
      r.token_index = idx;
      return r;
   endfunction

   function automatic logic is_sep(logic [7:0] c);
      return ((c != 8'd0) && (c <= CH_SPACE)) || c[7];
   endfunction

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = accept && (bundle_in.count != 2'd0);
   assign q_data    = bundle_in;

   always_comb begin
      phase_type          ph;
      logic               sp;
      logic [TOKEN_W-1:0] cnt;
      logic [1:0]         n;
      logic               go;
      logic               qon;
      bundle_type         b;

      ph  = phase_ff;
      sp  = slash_ff;
      cnt = count_ff;
      n   = 2'd0;
      go  = 1'b1;
      qon = !ignore_quotes;
      b   = '0;

      if (req_end_of_text || (ph != PH_STOPPED && req_ch == 8'd0)) begin
         // flush held slash and open token, then emit the done item or stop
         if (sp) begin
            sp = 1'b0;
            if (ph == PH_BETWEEN) begin
               if (cnt >= limit) begin
                  ph = PH_STOPPED;
                  go = 1'b0;
               end else begin
                  cnt = cnt + 11'd1;
                  ph  = PH_TOKEN;
               end
            end
            if (go) begin
               b.res[n] = mk(KIND_BYTE, CH_SLASH, cnt - 11'd1);
               n = n + 2'd1;
               b.res[n] = mk(KIND_END, 8'd0, cnt - 11'd1);
               n = n + 2'd1;
            end
         end else if (ph == PH_TOKEN || ph == PH_QUOTE) begin
            b.res[n] = mk(KIND_END, 8'd0, cnt - 11'd1);
            n = n + 2'd1;
         end
         if (req_end_of_text) begin
            b.res[n] = mk(KIND_DONE, 8'd0, cnt);
            n   = n + 2'd1;
            ph  = PH_BETWEEN;
            sp  = 1'b0;
            cnt = '0;
         end else begin
            ph = PH_STOPPED;
         end
      end else if (ph != PH_STOPPED) begin
         if (sp) begin
            sp = 1'b0;
            if (req_ch == CH_SLASH) begin
               if (ph == PH_TOKEN) begin
                  b.res[n] = mk(KIND_END, 8'd0, cnt - 11'd1);
                  n = n + 2'd1;
               end
               ph = PH_STOPPED;
               go = 1'b0;
            end else if (req_ch == CH_STAR) begin
               if (ph == PH_TOKEN) begin
                  b.res[n] = mk(KIND_END, 8'd0, cnt - 11'd1);
                  n  = n + 2'd1;
                  ph = (cnt >= limit) ? PH_STOPPED : PH_BETWEEN;
               end
               if (ph != PH_STOPPED) begin
                  ph = PH_COMMENT_STAR;
               end
               go = 1'b0;
            end else begin
               if (ph == PH_BETWEEN) begin
                  if (cnt >= limit) begin
                     ph = PH_STOPPED;
                     go = 1'b0;
                  end else begin
                     cnt = cnt + 11'd1;
                     ph  = PH_TOKEN;
                  end
               end
               if (go) begin
                  b.res[n] = mk(KIND_BYTE, CH_SLASH, cnt - 11'd1);
                  n = n + 2'd1;
               end
            end
         end
         if (go) begin
            unique case (ph)
               PH_BETWEEN: begin
                  if (is_sep(req_ch)) begin
                     ph = PH_BETWEEN;
                  end else if (req_ch == CH_SLASH) begin
                     sp = 1'b1;
                  end else if (cnt >= limit) begin
                     ph = PH_STOPPED;
                  end else if (qon && req_ch == CH_QUOTE) begin
                     cnt = cnt + 11'd1;
                     ph  = PH_QUOTE;
                  end else begin
                     cnt = cnt + 11'd1;
                     ph  = PH_TOKEN;
                     b.res[n] = mk(KIND_BYTE, req_ch, cnt - 11'd1);
                     n = n + 2'd1;
                  end
               end
               PH_TOKEN: begin
                  if (is_sep(req_ch) || (qon && req_ch == CH_QUOTE)) begin
                     b.res[n] = mk(KIND_END, 8'd0, cnt - 11'd1);
                     n  = n + 2'd1;
                     ph = (cnt >= limit) ? PH_STOPPED : PH_BETWEEN;
                     if (!is_sep(req_ch) && ph == PH_BETWEEN) begin
                        cnt = cnt + 11'd1;
                        ph  = PH_QUOTE;
                     end
                  end else if (req_ch == CH_SLASH) begin
                     sp = 1'b1;
                  end else begin
                     b.res[n] = mk(KIND_BYTE, req_ch, cnt - 11'd1);
                     n = n + 2'd1;
                  end
               end
               PH_QUOTE: begin
                  if (req_ch == CH_QUOTE) begin
                     b.res[n] = mk(KIND_END, 8'd0, cnt - 11'd1);
                     n  = n + 2'd1;
                     ph = (cnt >= limit) ? PH_STOPPED : PH_BETWEEN;
                  end else begin
                     b.res[n] = mk(KIND_BYTE, req_ch, cnt - 11'd1);
                     n = n + 2'd1;
                  end
               end
               PH_COMMENT: begin
                  if (req_ch == CH_STAR) begin
                     ph = PH_COMMENT_STAR;
                  end
               end
               PH_COMMENT_STAR: begin
                  if (req_ch == CH_SLASH) begin
                     ph = PH_BETWEEN;
                  end else if (req_ch != CH_STAR) begin
                     ph = PH_COMMENT;
                  end
               end
               default: begin
                  ph = PH_STOPPED;
               end
            endcase
         end
      end

      b.count   = n;
      phase_in  = ph;
      slash_in  = sp;
      count_in  = cnt;
      bundle_in = b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         slash_ff <= 1'b0;
         count_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         slash_ff <= slash_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/clt_queue.sv
module clt_queue import clt_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  bundle_type   push_data,
   input  logic         pop,
   output bundle_type   head,
   output q_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   bundle_type       entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> src/clt_back.sv
module clt_back import clt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  bundle_type         q_data,
   input  q_status_type       q_status,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_out_char,
   output logic [TOKEN_W-1:0] rsp_token_index,
   output logic               rsp_last
);

   logic               valid_ff;
   logic [1:0]         sub_ff;
   kind_type           kind_ff;
   logic [7:0]         char_ff;
   logic [TOKEN_W-1:0] index_ff;
   logic               last_ff;
   logic               out_free;
   logic               take;
   logic               is_last;
   result_type         cur;

   assign out_free = !valid_ff || !rsp_stall;
   assign take     = !q_status.empty && out_free;
   assign cur      = q_data.res[sub_ff];
   assign is_last  = (sub_ff == q_data.count - 2'd1);
   assign q_pop    = take && is_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= '0;
      end else begin
         if (out_free) begin
            valid_ff <= take;
         end
         if (take) begin
            sub_ff <= is_last ? 2'd0 : sub_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= cur.kind;
         char_ff  <= cur.out_char;
         index_ff <= cur.token_index;
         last_ff  <= is_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_out_char    = char_ff;
   assign rsp_token_index = index_ff;
   assign rsp_last        = last_ff;

endmodule
